// ----- hdl/triangle_jacobian_inverse_unit_assert.svh -----
// assertion macros for the triangle jacobian inverse unit
`ifndef TRIANGLE_JACOBIAN_INVERSE_UNIT_ASSERT_SVH
`define TRIANGLE_JACOBIAN_INVERSE_UNIT_ASSERT_SVH

// implication checked on every clock edge outside reset
`define TJI_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// implication checked in the cycle after the antecedent
`define TJI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

// ----- hdl/tji_pkg.sv -----
// shared types and constants for the triangle jacobian inverse unit
package tji_pkg;
    localparam int unsigned COORD_W  = 16;
    localparam int unsigned EDGE_W   = 17;
    localparam int unsigned DET_W    = 35;
    localparam int unsigned THR_W    = 34;
    localparam int unsigned INV_W    = 32;
    localparam int unsigned STAT_W   = 2;
    localparam int unsigned SHIFT    = 24;
    // dividend magnitude: |num| < 2^17, times 2^24
    localparam int unsigned DVD_W    = EDGE_W + SHIFT;
    localparam int unsigned QUO_W    = DVD_W;
    localparam int unsigned MAG_W    = DET_W - 1;
    localparam int unsigned LANES    = 4;

    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_WRONG    = 2'd1;
    localparam logic [STAT_W-1:0] ST_SINGULAR = 2'd2;

    // one lane of restoring division state handed from cell to cell
    typedef struct packed {
        logic [DVD_W-1:0] rem;
        logic [QUO_W-1:0] quo;
        logic             neg;
    } t_lane;

    // item control travelling with the lanes
    typedef struct packed {
        logic                    vld;
        logic [STAT_W-1:0]       status;
        logic signed [DET_W-1:0] det;
        logic [MAG_W-1:0]        mag;
    } t_ctrl;

    typedef struct packed {
        t_ctrl              ctrl;
        t_lane [LANES-1:0]  lane;
    } t_word;
endpackage

// ----- hdl/tji_front.sv -----
// edge differences, determinant and singularity test, three register stages
module tji_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic                           i_is_triangle,
    input  logic signed [tji_pkg::COORD_W-1:0] i_x0,
    input  logic signed [tji_pkg::COORD_W-1:0] i_y0,
    input  logic signed [tji_pkg::COORD_W-1:0] i_x1,
    input  logic signed [tji_pkg::COORD_W-1:0] i_y1,
    input  logic signed [tji_pkg::COORD_W-1:0] i_x2,
    input  logic signed [tji_pkg::COORD_W-1:0] i_y2,
    input  logic [tji_pkg::THR_W-1:0]      i_thr,
    output tji_pkg::t_word                 o_word
);
    import tji_pkg::*;

    logic                    r_v1, r_tri1;
    logic signed [EDGE_W-1:0] r_a, r_b, r_c, r_e;
    logic signed [EDGE_W-1:0] n_a, n_b, n_c, n_e;
    logic signed [EDGE_W-1:0] r_a_d, r_b_d, r_c_d, r_e_d;
    logic signed [2*EDGE_W-1:0] r_ae, r_bc;
    logic                    r_v2, r_tri2;
    logic signed [DET_W-1:0] w_det;
    logic [MAG_W:0]          w_mag;
    logic                    w_sing;
    t_word                   r_word, n_word;

    assign n_a = EDGE_W'(i_x1) - EDGE_W'(i_x0);
    assign n_b = EDGE_W'(i_x2) - EDGE_W'(i_x0);
    assign n_c = EDGE_W'(i_y1) - EDGE_W'(i_y0);
    assign n_e = EDGE_W'(i_y2) - EDGE_W'(i_y0);

    assign w_det  = DET_W'(r_ae) - DET_W'(r_bc);
    assign w_mag  = w_det[DET_W-1] ? (MAG_W+1)'(-w_det) : (MAG_W+1)'(w_det);
    assign w_sing = (w_mag == '0) || ({1'b0, w_mag} < {2'b0, i_thr});

    always_comb begin
        n_word = '0;
        n_word.ctrl.vld = r_v2;
        n_word.ctrl.mag = w_mag[MAG_W-1:0];
        if (!r_tri2) begin
            n_word.ctrl.status = ST_WRONG;
        end else if (w_sing) begin
            n_word.ctrl.status = ST_SINGULAR;
            n_word.ctrl.det    = w_det;
        end else begin
            n_word.ctrl.status = ST_OK;
            n_word.ctrl.det    = w_det;
        end
        // numerators e, -b, -c, a with 2^24 scale; sign of quotient
        for (int k = 0; k < LANES; k++) begin
            logic signed [EDGE_W:0] num;
            logic [EDGE_W-1:0]      nmag;
            num  = '0;
            unique case (k)
                0: num = (EDGE_W+1)'(r_e_d);
                1: num = -(EDGE_W+1)'(r_b_d);
                2: num = -(EDGE_W+1)'(r_c_d);
                default: num = (EDGE_W+1)'(r_a_d);
            endcase
            nmag = num[EDGE_W] ? EDGE_W'(-num) : EDGE_W'(num);
            n_word.lane[k].rem = {nmag, {SHIFT{1'b0}}};
            n_word.lane[k].quo = '0;
            n_word.lane[k].neg = num[EDGE_W] ^ w_det[DET_W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_word.ctrl.vld <= 1'b0;
        end else begin
            r_v1 <= i_start;
            r_v2 <= r_v1;
            r_word.ctrl.vld <= n_word.ctrl.vld;
        end
        r_tri1 <= i_is_triangle;
        r_a <= n_a; r_b <= n_b; r_c <= n_c; r_e <= n_e;
        r_tri2 <= r_tri1;
        r_ae <= r_a * r_e;
        r_bc <= r_b * r_c;
        r_a_d <= r_a; r_b_d <= r_b; r_c_d <= r_c; r_e_d <= r_e;
        r_word.ctrl.status <= n_word.ctrl.status;
        r_word.ctrl.det    <= n_word.ctrl.det;
        r_word.ctrl.mag    <= n_word.ctrl.mag;
        r_word.lane        <= n_word.lane;
    end

    assign o_word = r_word;
endmodule

// ----- hdl/tji_cell.sv -----
// one quotient bit of four restoring divisions
module tji_cell #(
    parameter int unsigned BIT = 0
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  tji_pkg::t_word i_word,
    output tji_pkg::t_word o_word
);
    import tji_pkg::*;

    t_word r_word, n_word;

    always_comb begin
        n_word = i_word;
        for (int k = 0; k < LANES; k++) begin
            logic [DVD_W+MAG_W-1:0] dsh;
            dsh = (DVD_W+MAG_W)'(i_word.ctrl.mag) << BIT;
            if ({{MAG_W{1'b0}}, i_word.lane[k].rem} >= dsh) begin
                n_word.lane[k].rem = i_word.lane[k].rem - DVD_W'(dsh);
                n_word.lane[k].quo[BIT] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word.ctrl.vld <= 1'b0;
        end else begin
            r_word.ctrl.vld <= n_word.ctrl.vld;
        end
        r_word.ctrl.status <= n_word.ctrl.status;
        r_word.ctrl.det    <= n_word.ctrl.det;
        r_word.ctrl.mag    <= n_word.ctrl.mag;
        r_word.lane        <= n_word.lane;
    end

    assign o_word = r_word;
endmodule

// ----- hdl/tji_back.sv -----
// sign, saturation and error zeroing of the quotients
module tji_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  tji_pkg::t_word                    i_word,
    output logic                              o_done,
    output logic [tji_pkg::STAT_W-1:0]        o_status,
    output logic signed [tji_pkg::DET_W-1:0]  o_det,
    output logic signed [tji_pkg::INV_W-1:0]  o_inv [tji_pkg::LANES]
);
    import tji_pkg::*;

    logic                    r_done;
    logic [STAT_W-1:0]       r_status;
    logic signed [DET_W-1:0] r_det;
    logic signed [INV_W-1:0] r_inv [LANES];
    logic signed [INV_W-1:0] n_inv [LANES];

    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            logic [QUO_W-1:0] q;
            q = i_word.lane[k].quo;
            if (i_word.ctrl.status != ST_OK) begin
                n_inv[k] = '0;
            end else if (i_word.lane[k].neg) begin
                n_inv[k] = (q > (QUO_W'(1) << (INV_W-1))) ?
                    {1'b1, {(INV_W-1){1'b0}}} : INV_W'(-q);
            end else begin
                n_inv[k] = (q > QUO_W'({1'b0, {(INV_W-1){1'b1}}})) ?
                    {1'b0, {(INV_W-1){1'b1}}} : INV_W'(q);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_word.ctrl.vld;
        end
        r_status <= i_word.ctrl.status;
        r_det    <= i_word.ctrl.det;
        r_inv    <= n_inv;
    end

    assign o_done   = r_done;
    assign o_status = r_status;
    assign o_det    = r_det;
    assign o_inv    = r_inv;
endmodule

// ----- hdl/triangle_jacobian_inverse_unit.sv -----
// pipeline: 3 + QUO_W + 1 = 45 register stages from the accepting edge to o_done
// throughput: one triangle per cycle; busy stays low, the chain never stalls
// one division cell per quotient bit sets the latency; all four entries share it
// reset (synchronous, active low) empties the chain and sets the threshold to 1
// results show for one cycle on o_done; the receiver cannot hold them off
// the config channel is always ready; write only while the chain is empty
module triangle_jacobian_inverse_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               i_is_triangle,
    input  logic signed [tji_pkg::COORD_W-1:0] i_vertex0_x,
    input  logic signed [tji_pkg::COORD_W-1:0] i_vertex0_y,
    input  logic signed [tji_pkg::COORD_W-1:0] i_vertex1_x,
    input  logic signed [tji_pkg::COORD_W-1:0] i_vertex1_y,
    input  logic signed [tji_pkg::COORD_W-1:0] i_vertex2_x,
    input  logic signed [tji_pkg::COORD_W-1:0] i_vertex2_y,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [tji_pkg::THR_W-1:0]          i_cfg_data,
    output logic                               o_done,
    output logic [tji_pkg::STAT_W-1:0]         o_status,
    output logic signed [tji_pkg::DET_W-1:0]   o_determinant,
    output logic signed [tji_pkg::INV_W-1:0]   o_inv_xx,
    output logic signed [tji_pkg::INV_W-1:0]   o_inv_xy,
    output logic signed [tji_pkg::INV_W-1:0]   o_inv_yx,
    output logic signed [tji_pkg::INV_W-1:0]   o_inv_yy
);
    import tji_pkg::*;

    logic [THR_W-1:0]        r_thr;
    t_word                   w_chain [QUO_W+1];
    logic signed [INV_W-1:0] w_inv [LANES];

    // threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_W'(1);
        end else if (i_cfg_valid) begin
            r_thr <= i_cfg_data;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign busy        = 1'b0;

    tji_front u_front (
        .i_clk, .i_rst_n, .i_start(start), .i_is_triangle,
        .i_x0(i_vertex0_x), .i_y0(i_vertex0_y),
        .i_x1(i_vertex1_x), .i_y1(i_vertex1_y),
        .i_x2(i_vertex2_x), .i_y2(i_vertex2_y),
        .i_thr(r_thr), .o_word(w_chain[0])
    );

    // cells from the most significant quotient bit down
    for (genvar g = 0; g < QUO_W; g++) begin : g_cell
        tji_cell #(.BIT(QUO_W-1-g)) u_cell (
            .i_clk, .i_rst_n, .i_word(w_chain[g]), .o_word(w_chain[g+1])
        );
    end

    tji_back u_back (
        .i_clk, .i_rst_n, .i_word(w_chain[QUO_W]),
        .o_done, .o_status, .o_det(o_determinant), .o_inv(w_inv)
    );

    assign o_inv_xx = w_inv[0];
    assign o_inv_xy = w_inv[1];
    assign o_inv_yx = w_inv[2];
    assign o_inv_yy = w_inv[3];
endmodule

// ----- hdl/tji_checker.sv -----
// port-level checks for the triangle jacobian inverse unit
`include "triangle_jacobian_inverse_unit_assert.svh"
module tji_port_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             o_done,
    input logic [tji_pkg::STAT_W-1:0]       o_status,
    input logic signed [tji_pkg::DET_W-1:0] o_determinant,
    input logic signed [tji_pkg::INV_W-1:0] o_inv_xx,
    input logic signed [tji_pkg::INV_W-1:0] o_inv_yy
);
    import tji_pkg::*;

    `TJI_ASSERT_IMPL(a_wrong_zero_det, i_clk, i_rst_n,
        o_done && o_status == ST_WRONG, o_determinant == '0)
    `TJI_ASSERT_IMPL(a_err_zero_inv, i_clk, i_rst_n,
        o_done && o_status != ST_OK, o_inv_xx == '0 && o_inv_yy == '0)
    `TJI_ASSERT_IMPL(a_ok_nonzero_det, i_clk, i_rst_n,
        o_done && o_status == ST_OK, o_determinant != '0)
    `TJI_ASSERT_IMPL(a_status_code, i_clk, i_rst_n,
        o_done, o_status == ST_OK || o_status == ST_WRONG || o_status == ST_SINGULAR)
endmodule

bind triangle_jacobian_inverse_unit tji_port_checker u_tji_checker (
    .i_clk, .i_rst_n, .o_done, .o_status, .o_determinant, .o_inv_xx, .o_inv_yy
);
